// ===== rtl/fpba_pkg.sv =====
// Shared types and constants for the fit-policy block allocator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package fpba_pkg;

	localparam int NUM_BLOCKS = 64;
	localparam int SIZE_BITS  = 16;

	localparam int IDX_BITS = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CNT_BITS = $clog2(NUM_BLOCKS + 1);

	// Fixed port widths.
	localparam int BLK_IDX_W = 6;
	localparam int SIZE_W    = 16;
	localparam int COUNT_W   = 7;
	localparam int POLICY_W  = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 7;

	localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
	localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
	localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_REQUEST = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_WRBK
	} fpba_state_t;

	// One access to the block table: one read port and one write port.
	typedef struct packed {
		logic                 rd_en;
		logic [IDX_BITS-1:0]  rd_addr;
		logic                 wr_en;
		logic                 wr_orig;
		logic [IDX_BITS-1:0]  wr_addr;
		logic [SIZE_BITS-1:0] wr_data;
	} fpba_mem_req_t;

	typedef struct packed {
		logic [SIZE_BITS-1:0] remaining;
		logic [SIZE_BITS-1:0] original;
	} fpba_mem_rd_t;

endpackage

// ===== rtl/fpba_mem.sv =====
// Block table: remaining and original size per block, synchronous read.
// Depends on fpba_pkg for the table depth, word width and access structs.
`timescale 1ns / 1ps

module fpba_mem (
	input  logic                   clk,
	input  fpba_pkg::fpba_mem_req_t req,
	output fpba_pkg::fpba_mem_rd_t  rd
);
	import fpba_pkg::*;

	logic [SIZE_BITS-1:0] remaining_mem [NUM_BLOCKS];
	logic [SIZE_BITS-1:0] original_mem  [NUM_BLOCKS];
	fpba_mem_rd_t         rd_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			remaining_mem[req.wr_addr] <= req.wr_data;
			if (req.wr_orig) begin
				original_mem[req.wr_addr] <= req.wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_q.remaining <= remaining_mem[req.rd_addr];
			rd_q.original  <= original_mem[req.rd_addr];
		end
	end

	assign rd = rd_q;

endmodule

// ===== rtl/fpba_ctrl.sv =====
// Sequencer: loads blocks, scans the table one entry per cycle and charges the pick.
// Depends on fpba_pkg for states, policy codes and the table access structs.
`timescale 1ns / 1ps

module fpba_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             mode,
	input  logic [fpba_pkg::BLK_IDX_W-1:0]   block_index,
	input  logic [fpba_pkg::SIZE_W-1:0]      size,
	input  logic [fpba_pkg::POLICY_W-1:0]    fit_policy,
	input  logic [fpba_pkg::COUNT_W-1:0]     block_count,
	output fpba_pkg::fpba_mem_req_t          mem_req,
	input  fpba_pkg::fpba_mem_rd_t           mem_rd,
	output logic                             done,
	output logic                             granted,
	output logic [fpba_pkg::BLK_IDX_W-1:0]   chosen_block,
	output logic [fpba_pkg::SIZE_W-1:0]      block_total,
	output logic [fpba_pkg::SIZE_W-1:0]      block_remaining
);
	import fpba_pkg::*;

	fpba_state_t          state_q, state_d;
	logic [CNT_BITS-1:0]  scan_q;
	logic [CNT_BITS-1:0]  last_q;
	logic [POLICY_W-1:0]  policy_q;
	logic [SIZE_BITS-1:0] req_size_q;
	logic                 rd_valid_s1;
	logic [IDX_BITS-1:0]  rd_idx_s1;
	logic                 found_q;
	logic [IDX_BITS-1:0]  pick_idx_q;
	logic [SIZE_BITS-1:0] pick_rem_q;
	logic [SIZE_BITS-1:0] pick_orig_q;
	logic                 done_q;
	logic                 granted_q;
	logic [BLK_IDX_W-1:0] chosen_q;
	logic [SIZE_W-1:0]    total_q;
	logic [SIZE_W-1:0]    remain_q;

	logic                 accept;
	logic                 load_ok;
	logic [CNT_BITS-1:0]  limit;
	logic [SIZE_BITS-1:0] in_size;
	logic                 fits;
	logic                 take;
	logic [SIZE_BITS-1:0] charged;

	assign accept  = start && (state_q == ST_IDLE);
	assign in_size = SIZE_BITS'(size);
	assign load_ok = (32'(block_index) < NUM_BLOCKS);
	assign limit   = (32'(block_count) > NUM_BLOCKS) ? CNT_BITS'(NUM_BLOCKS)
	                                                 : CNT_BITS'(block_count);

	// A candidate replaces the current pick on the first fit, or when it is
	// strictly smaller (best fit) or strictly larger (worst fit).
	assign fits = (mem_rd.remaining >= req_size_q);
	always_comb begin
		take = 1'b0;
		if (rd_valid_s1 && fits) begin
			if (!found_q) begin
				take = 1'b1;
			end else begin
				case (policy_q)
					POL_BEST:  take = (mem_rd.remaining < pick_rem_q);
					POL_WORST: take = (mem_rd.remaining > pick_rem_q);
					default:   take = 1'b0;
				endcase
			end
		end
	end

	assign charged = pick_rem_q - req_size_q;

	always_comb begin
		state_d         = state_q;
		mem_req.rd_en   = 1'b0;
		mem_req.rd_addr = scan_q[IDX_BITS-1:0];
		mem_req.wr_en   = 1'b0;
		mem_req.wr_orig = 1'b0;
		mem_req.wr_addr = IDX_BITS'(block_index);
		mem_req.wr_data = in_size;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (mode == MODE_LOAD) begin
						mem_req.wr_en   = load_ok;
						mem_req.wr_orig = 1'b1;
					end else if (limit == '0) begin
						state_d = ST_WRBK;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				mem_req.rd_en = 1'b1;
				if (scan_q == last_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_WRBK;
			end
			ST_WRBK: begin
				mem_req.wr_en   = found_q;
				mem_req.wr_addr = pick_idx_q;
				mem_req.wr_data = charged;
				state_d         = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_valid_s1 <= 1'b0;
			found_q     <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= (state_q == ST_SCAN);
			done_q      <= (state_q == ST_WRBK);
			if (accept) begin
				found_q <= 1'b0;
			end else if (take) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_q[IDX_BITS-1:0];
		if (accept) begin
			scan_q     <= '0;
			last_q     <= limit - CNT_BITS'(1);
			policy_q   <= fit_policy;
			req_size_q <= in_size;
		end else if (state_q == ST_SCAN) begin
			scan_q <= scan_q + CNT_BITS'(1);
		end
		if (take) begin
			pick_idx_q  <= rd_idx_s1;
			pick_rem_q  <= mem_rd.remaining;
			pick_orig_q <= mem_rd.original;
		end
		if (state_q == ST_WRBK) begin
			granted_q <= found_q;
			if (found_q) begin
				chosen_q <= BLK_IDX_W'(pick_idx_q);
				total_q  <= SIZE_W'(pick_orig_q);
				remain_q <= SIZE_W'(charged);
			end else begin
				chosen_q <= '0;
				total_q  <= '0;
				remain_q <= '0;
			end
		end
	end

	assign busy            = (state_q != ST_IDLE);
	assign done            = done_q;
	assign granted         = granted_q;
	assign chosen_block    = chosen_q;
	assign block_total     = total_q;
	assign block_remaining = remain_q;

endmodule

// ===== rtl/fit_policy_block_allocator.sv =====
// Top level of the fit-policy block allocator: configuration registers and instances.
// Depends on fpba_pkg, fpba_mem and fpba_ctrl.
//
//   channel  handshake              beat fields
//   -------  ---------------------  ---------------------------------------------
//   input    start high, busy low   mode, block_index, size
//   result   done (one cycle)       granted, chosen_block, block_total,
//                                   block_remaining
//   config   cfg_valid, cfg_ready   cfg_index, cfg_data
//
// A load gives no result and does not leave the idle state. A request with L blocks in use
// (block_count saturated at the table depth) runs through the accepting cycle, one
// table read per block through the single read port, a drain state for the last read
// data and one write-back of the charged block; with no block in use it skips the scan
// and the drain. done pulses in the cycle after the write-back.
// Reset clears the control state and the configuration registers; the table holds garbage
// until blocks are loaded. The result cannot be stalled; cfg_ready is always high.
`timescale 1ns / 1ps

module fit_policy_block_allocator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            mode,
	input  logic [fpba_pkg::BLK_IDX_W-1:0]  block_index,
	input  logic [fpba_pkg::SIZE_W-1:0]     size,
	output logic                            done,
	output logic                            granted,
	output logic [fpba_pkg::BLK_IDX_W-1:0]  chosen_block,
	output logic [fpba_pkg::SIZE_W-1:0]     block_total,
	output logic [fpba_pkg::SIZE_W-1:0]     block_remaining,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fpba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fpba_pkg::CFG_DAT_W-1:0]  cfg_data
);
	import fpba_pkg::*;

	logic [POLICY_W-1:0] fit_policy_q;
	logic [COUNT_W-1:0]  block_count_q;
	fpba_mem_req_t       mem_req;
	fpba_mem_rd_t        mem_rd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_policy_q  <= POL_FIRST;
			block_count_q <= COUNT_W'(64);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FIT_POLICY:  fit_policy_q  <= cfg_data[POLICY_W-1:0];
				REG_BLOCK_COUNT: block_count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	fpba_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.mode            (mode),
		.block_index     (block_index),
		.size            (size),
		.fit_policy      (fit_policy_q),
		.block_count     (block_count_q),
		.mem_req         (mem_req),
		.mem_rd          (mem_rd),
		.done            (done),
		.granted         (granted),
		.chosen_block    (chosen_block),
		.block_total     (block_total),
		.block_remaining (block_remaining)
	);

	fpba_mem u_mem (
		.clk (clk),
		.req (mem_req),
		.rd  (mem_rd)
	);

endmodule
